// File: rtl/msr_pkg.sv
// types and constants shared by the motor speed ramp block
// no dependencies
`default_nettype none

package msr_pkg;

    localparam int DUTY_W = 8;
    localparam int TICK_W = 16;
    localparam int PROD_W = DUTY_W + TICK_W;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [DUTY_W-1:0] DUTY_MAX    = 8'd255;
    localparam logic [TICK_W-1:0] FADE_RESET  = 16'd1000;
    localparam logic [TICK_W-1:0] TICK_SAT    = 16'hffff;

    // register index decoded from paddr[2]
    localparam logic REG_FADE_DURATION = 1'b0;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_FORWARD = 2'd1,
        OP_REVERSE = 2'd2,
        OP_STOP    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_HOLD
    } state_t;

    // request to the divider
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [TICK_W-1:0] divisor;
    } div_req_t;

    // divider result
    typedef struct packed {
        logic              done;
        logic [DUTY_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/msr_regs.sv
// apb configuration register holding the ramp length
// depends on msr_pkg
`default_nettype none

module msr_regs import msr_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    output logic      [TICK_W-1:0] fade_duration
);

    logic [TICK_W-1:0] fade_reg;
    logic [TICK_W-1:0] fade_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_FADE_DURATION);

    // write decode
    always_comb begin
        fade_next = fade_reg;
        if (wr_en) begin
            fade_next = pwdata[TICK_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_reg <= FADE_RESET;
        end else begin
            fade_reg <= fade_next;
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FADE_DURATION) begin
            prdata = {{(APB_DW-TICK_W){1'b0}}, fade_reg};
        end
    end

    assign fade_duration = fade_reg;

endmodule

`default_nettype wire

// File: rtl/msr_divider.sv
// restoring divider, one quotient bit per cycle, eight-bit quotient
// depends on msr_pkg; caller guarantees dividend < 256 * divisor
`default_nettype none

module msr_divider import msr_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [DUTY_W-1:0] dvd_reg, dvd_next;
    logic [DUTY_W-1:0] quo_reg, quo_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TICK_W:0]   trial;
    logic              fits;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, dvd_reg[DUTY_W-1]};
    assign fits  = trial >= {1'b0, req.divisor};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.dividend[PROD_W-1:DUTY_W];
            dvd_next  = req.dividend[DUTY_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = trial[TICK_W-1:0] - req.divisor;
            end else begin
                rem_next = trial[TICK_W-1:0];
            end
            dvd_next = {dvd_reg[DUTY_W-2:0], 1'b0};
            quo_next = {quo_reg[DUTY_W-2:0], fits};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/motor_speed_ramp_with_reversal_top.sv
// motor duty ramp with direction reversal: command sequencer and state
// depends on msr_pkg, msr_regs, msr_divider
//
// usage: s_ channel takes one request (operation, speed): a one-millisecond
// tick, forward, reverse or stop. every request gives exactly one result on
// the m_ channel: duty, direction lines, ramping and running after it.
// order: commands, ticks outside a ramp and ticks that end a ramp put
// their result in the output register on the edge that accepts them. a
// tick inside a ramp advances the tick count, runs the 16x8 multiply,
// loads the divider, takes eight divide steps, writes the duty and then
// loads the output register.
// throughput: one request at a time; s_ready is high while the sequencer is
// idle and the output register is empty or being taken, so a new request
// can enter as the previous result leaves.
// stall: if m_ready stays low the result holds in the output register and
// s_ready drops until it is taken; a finished divide waits the same way.
// reset: aresetn low (synchronous) clears the duty, lines, flags and the
// output valid bit, sets the ramp length to 1000 ticks; no clearing pass.
// the apb port writes the ramp length at byte address 0; pready is always
// high; writes are expected only while the block is idle.
`default_nettype none

module motor_speed_ramp_with_reversal_top import msr_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // request channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_operation,
    input  wire logic [DUTY_W-1:0] s_speed,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [DUTY_W-1:0] m_duty,
    output logic                   m_drive_a,
    output logic                   m_drive_b,
    output logic                   m_ramping,
    output logic                   m_running,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    logic [TICK_W-1:0] fade_duration;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    state_t            state_reg, state_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [DUTY_W-1:0] start_reg, start_next;
    logic [DUTY_W-1:0] target_reg, target_next;
    logic [TICK_W-1:0] elapsed_reg, elapsed_next;
    logic              active_reg, active_next;
    logic              motion_reg, motion_next;
    logic              rev_pend_reg, rev_pend_next;
    logic              pend_dir_reg, pend_dir_next;
    logic [DUTY_W-1:0] pend_speed_reg, pend_speed_next;
    logic              line_a_reg, line_a_next;
    logic              line_b_reg, line_b_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              neg_reg, neg_next;

    logic              out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0] out_duty_reg;
    logic              out_a_reg, out_b_reg, out_ramp_reg, out_run_reg;

    logic              out_free;
    logic              accept;
    logic              load_out;
    logic              rev_cmd;
    logic              opp_high;
    logic [TICK_W-1:0] elapsed_inc;
    logic [DUTY_W-1:0] diff_mag;
    logic              diff_neg;
    logic [DUTY_W+1:0] value;
    op_t               op;

    msr_regs u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fade_duration (fade_duration)
    );

    msr_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign op       = op_t'(s_operation);
    assign rev_cmd  = (op == OP_REVERSE);
    assign opp_high = rev_cmd ? line_a_reg : line_b_reg;

    assign elapsed_inc = (elapsed_reg < TICK_SAT) ? elapsed_reg + 16'd1 : elapsed_reg;

    // magnitude and sign of target - start
    assign diff_neg = target_reg < start_reg;
    assign diff_mag = diff_neg ? start_reg - target_reg : target_reg - start_reg;

    // start +/- quotient, clamped to the duty range
    always_comb begin
        if (neg_reg) begin
            value = {2'b00, start_reg} - {2'b00, div_rsp.quotient};
        end else begin
            value = {2'b00, start_reg} + {2'b00, div_rsp.quotient};
        end
    end

    assign div_req.start    = (state_reg == ST_START);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = fade_duration;

    // sequencer and ramp state
    always_comb begin
        state_next      = state_reg;
        duty_next       = duty_reg;
        start_next      = start_reg;
        target_next     = target_reg;
        elapsed_next    = elapsed_reg;
        active_next     = active_reg;
        motion_next     = motion_reg;
        rev_pend_next   = rev_pend_reg;
        pend_dir_next   = pend_dir_reg;
        pend_speed_next = pend_speed_reg;
        line_a_next     = line_a_reg;
        line_b_next     = line_b_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        load_out        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_TICK: begin
                            load_out = 1'b1;
                            if (active_reg) begin
                                elapsed_next = elapsed_inc;
                                if (elapsed_inc >= fade_duration) begin
                                    // ramp done, maybe start the reversed leg
                                    duty_next   = target_reg;
                                    active_next = 1'b0;
                                    if (rev_pend_reg && (target_reg == '0)) begin
                                        line_a_next   = !pend_dir_reg;
                                        line_b_next   = pend_dir_reg;
                                        start_next    = '0;
                                        target_next   = pend_speed_reg;
                                        elapsed_next  = '0;
                                        active_next   = 1'b1;
                                        rev_pend_next = 1'b0;
                                        motion_next   = 1'b1;
                                    end
                                end else begin
                                    load_out   = 1'b0;
                                    state_next = ST_MUL;
                                end
                            end
                        end
                        OP_FORWARD, OP_REVERSE: begin
                            load_out     = 1'b1;
                            start_next   = duty_reg;
                            elapsed_next = '0;
                            active_next  = 1'b1;
                            if ((motion_reg || active_reg) && opp_high) begin
                                // ramp down first, hold the new direction
                                target_next     = '0;
                                rev_pend_next   = 1'b1;
                                pend_dir_next   = rev_cmd;
                                pend_speed_next = s_speed;
                            end else begin
                                target_next = s_speed;
                                line_a_next = !rev_cmd;
                                line_b_next = rev_cmd;
                                motion_next = 1'b1;
                            end
                        end
                        OP_STOP: begin
                            load_out = 1'b1;
                            if (motion_reg || (duty_reg != '0)) begin
                                if (!active_reg) begin
                                    rev_pend_next = 1'b0;
                                end
                                start_next   = duty_reg;
                                target_next  = '0;
                                elapsed_next = '0;
                                active_next  = 1'b1;
                                motion_next  = 1'b0;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                prod_next  = PROD_W'(elapsed_reg) * PROD_W'(diff_mag);
                neg_next   = diff_neg;
                state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    if (value[DUTY_W+1]) begin
                        duty_next = '0;
                    end else if (value[DUTY_W]) begin
                        duty_next = DUTY_MAX;
                    end else begin
                        duty_next = value[DUTY_W-1:0];
                    end
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            duty_reg       <= '0;
            start_reg      <= '0;
            target_reg     <= '0;
            elapsed_reg    <= '0;
            active_reg     <= 1'b0;
            motion_reg     <= 1'b0;
            rev_pend_reg   <= 1'b0;
            pend_dir_reg   <= 1'b0;
            pend_speed_reg <= '0;
            line_a_reg     <= 1'b0;
            line_b_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            duty_reg       <= duty_next;
            start_reg      <= start_next;
            target_reg     <= target_next;
            elapsed_reg    <= elapsed_next;
            active_reg     <= active_next;
            motion_reg     <= motion_next;
            rev_pend_reg   <= rev_pend_next;
            pend_dir_reg   <= pend_dir_next;
            pend_speed_reg <= pend_speed_next;
            line_a_reg     <= line_a_next;
            line_b_reg     <= line_b_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        if (load_out) begin
            out_duty_reg <= duty_next;
            out_a_reg    <= line_a_next;
            out_b_reg    <= line_b_next;
            out_ramp_reg <= active_next;
            out_run_reg  <= motion_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_duty    = out_duty_reg;
    assign m_drive_a = out_a_reg;
    assign m_drive_b = out_b_reg;
    assign m_ramping = out_ramp_reg;
    assign m_running = out_run_reg;

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// testbench for motor_speed_ramp_with_reversal_top: a directed table, then random traffic
// each result is checked against a literal row or an in-bench model of duty ramp and lines
// depends on msr_pkg and the rtl of motor_speed_ramp_with_reversal_top

module testbench import msr_pkg::*; ();

    localparam int unsigned RANDOM_REQUESTS = 1450;
    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam int unsigned HOLD_CYCLES     = 400;
    // longest path through the block is a tick inside a ramp
    localparam int unsigned SETTLE_CYCLES   = 16;
    localparam logic [APB_AW-1:0] FADE_ADDR  = 3'd0;
    // second register slot, not implemented, writes must be dropped
    localparam logic [APB_AW-1:0] SPARE_ADDR = 3'd4;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              drive_a;
        logic              drive_b;
        logic              ramping;
        logic              running;
    } motor_out_t;

    typedef struct {
        bit                is_write;
        logic [APB_AW-1:0] addr;
        logic [APB_DW-1:0] data;
        op_t               op;
        logic [DUTY_W-1:0] speed;
        bit                literal;
        motor_out_t        want;
    } step_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_operation = OP_TICK;
    logic [DUTY_W-1:0] s_speed = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DUTY_W-1:0] m_duty;
    logic              m_drive_a;
    logic              m_drive_b;
    logic              m_ramping;
    logic              m_running;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    motor_out_t  expected_outputs[$];
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned ticks_sent = 0;
    int unsigned commands_sent = 0;
    int unsigned results_checked = 0;
    int unsigned register_writes = 0;
    int unsigned reversals_done = 0;
    bit          sender_steady = 1'b0;
    bit          output_hold_req = 1'b0;

    // predicted state of the block
    logic [TICK_W-1:0] fade_len;
    logic [DUTY_W-1:0] duty_now;
    logic [DUTY_W-1:0] ramp_from;
    logic [DUTY_W-1:0] ramp_to;
    logic [TICK_W-1:0] ramp_ticks;
    logic              in_ramp;
    logic              moving;
    logic              reversal_wait;
    logic              reversal_dir;
    logic [DUTY_W-1:0] reversal_speed;
    logic              line_fwd;
    logic              line_rev;

    motor_speed_ramp_with_reversal_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_speed     (s_speed),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_duty      (m_duty),
        .m_drive_a   (m_drive_a),
        .m_drive_b   (m_drive_b),
        .m_ramping   (m_ramping),
        .m_running   (m_running),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------- ramp predictor ----------------

    function automatic void reset_predictor();
        fade_len       = FADE_RESET;
        duty_now       = '0;
        ramp_from      = '0;
        ramp_to        = '0;
        ramp_ticks     = '0;
        in_ramp        = 1'b0;
        moving         = 1'b0;
        reversal_wait  = 1'b0;
        reversal_dir   = 1'b0;
        reversal_speed = '0;
        line_fwd       = 1'b0;
        line_rev       = 1'b0;
    endfunction

    function automatic void start_ramp(logic [DUTY_W-1:0] from_duty,
                                       logic [DUTY_W-1:0] to_duty);
        ramp_from  = from_duty;
        ramp_to    = to_duty;
        ramp_ticks = '0;
        in_ramp    = 1'b1;
    endfunction

    function automatic void set_direction(logic reverse);
        line_fwd = !reverse;
        line_rev = reverse;
    endfunction

    function automatic void run_command(logic reverse, logic [DUTY_W-1:0] speed);
        logic opposite_high;
        opposite_high = reverse ? line_fwd : line_rev;
        // against the present direction: ramp down first, hold the new target
        if ((moving || in_ramp) && opposite_high) begin
            start_ramp(duty_now, '0);
            reversal_wait  = 1'b1;
            reversal_dir   = reverse;
            reversal_speed = speed;
            return;
        end
        start_ramp(duty_now, speed);
        set_direction(reverse);
        moving = 1'b1;
    endfunction

    function automatic void stop_command();
        if (!moving && duty_now == 0)
            return;
        // a stop during a ramp keeps a pending reversal alive
        if (!in_ramp)
            reversal_wait = 1'b0;
        start_ramp(duty_now, '0);
        moving = 1'b0;
    endfunction

    function automatic void advance_tick();
        int span;
        int level;
        if (!in_ramp)
            return;
        if (ramp_ticks != TICK_SAT)
            ramp_ticks = ramp_ticks + 1'b1;
        // ramp end, possibly turning around into the held direction
        if (ramp_ticks >= fade_len) begin
            duty_now = ramp_to;
            in_ramp  = 1'b0;
            if (reversal_wait && duty_now == 0) begin
                set_direction(reversal_dir);
                start_ramp('0, reversal_speed);
                reversal_wait = 1'b0;
                moving        = 1'b1;
                reversals_done++;
            end
            return;
        end
        // linear step, division truncates toward zero
        span  = int'(ramp_to) - int'(ramp_from);
        level = int'(ramp_from) + (int'(ramp_ticks) * span) / int'(fade_len);
        if (level < 0)
            level = 0;
        if (level > int'(DUTY_MAX))
            level = int'(DUTY_MAX);
        duty_now = level[DUTY_W-1:0];
    endfunction

    function automatic motor_out_t predict_motor(op_t op, logic [DUTY_W-1:0] speed);
        case (op)
            OP_TICK:    advance_tick();
            OP_FORWARD: run_command(1'b0, speed);
            OP_REVERSE: run_command(1'b1, speed);
            default:    stop_command();
        endcase
        return {duty_now, line_fwd, line_rev, in_ramp, moving};
    endfunction

    // ---------------- random helpers ----------------

    // idle length: mostly short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned pick_send_gap();
        if (sender_steady || $urandom_range(0, 99) < 55)
            return 0;
        return pick_gap();
    endfunction

    function automatic logic [DUTY_W-1:0] pick_speed();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return DUTY_MAX;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void check_field(string name, logic [DUTY_W-1:0] want,
                                        logic [DUTY_W-1:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // ---------------- directed table rows ----------------

    function automatic step_row_t row_request(op_t op, logic [DUTY_W-1:0] speed);
        step_row_t row;
        row = '{is_write: 1'b0, addr: '0, data: '0, op: op, speed: speed,
                literal: 1'b0, want: '0};
        return row;
    endfunction

    function automatic step_row_t row_known(op_t op, logic [DUTY_W-1:0] speed, motor_out_t want);
        step_row_t row;
        row = row_request(op, speed);
        row.literal = 1'b1;
        row.want    = want;
        return row;
    endfunction

    function automatic step_row_t row_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        step_row_t row;
        row = row_request(OP_TICK, '0);
        row.is_write = 1'b1;
        row.addr     = addr;
        row.data     = data;
        return row;
    endfunction

    // ---------------- bus tasks ----------------

    // one request on the s_ channel, prediction taken at acceptance
    task automatic send_request(input op_t op, input logic [DUTY_W-1:0] speed,
                                input bit use_literal, input motor_out_t literal);
        motor_out_t predicted;
        int unsigned gap;
        gap = pick_send_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_speed     <= speed;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_motor(op, speed);
        expected_outputs.push_back(use_literal ? literal : predicted);
        if (op == OP_TICK)
            ticks_sent++;
        else
            commands_sent++;
    endtask

    task automatic apb_transfer(input logic wr, input logic [APB_AW-1:0] addr,
                                input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // register write once the block has drained, then read back the ramp length
    task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        logic [APB_DW-1:0] readback;
        s_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        apb_transfer(1'b1, addr, data, readback);
        if (addr == FADE_ADDR)
            fade_len = data[TICK_W-1:0];
        register_writes++;
        apb_transfer(1'b0, FADE_ADDR, '0, readback);
        if (readback !== APB_DW'(fade_len)) begin
            error_count++;
            $display("%0t: fade_duration_ms readback mismatch, expected %0d, got %0d",
                     $time, fade_len, readback);
        end
    endtask

    // ---------------- watchdog ----------------

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still due", cycle_count,
                 expected_outputs.size());
        $display("FAILURE");
        $finish;
    end

    // ---------------- result side: back-pressure and checking ----------------

    initial begin : result_side
        motor_out_t  got;
        motor_out_t  want;
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned steady_left;
        stall_left  = 0;
        hold_left   = 0;
        steady_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = {m_duty, m_drive_a, m_drive_b, m_ramping, m_running};
                results_checked++;
                if (expected_outputs.size() == 0) begin
                    error_count++;
                    $display("%0t: result with none expected, got duty %0d a %0b b %0b",
                             $time, got.duty, got.drive_a, got.drive_b);
                    $display("    ramping %0b running %0b", got.ramping, got.running);
                end else begin
                    want = expected_outputs.pop_front();
                    check_field("duty", want.duty, got.duty);
                    check_field("drive_a", DUTY_W'(want.drive_a), DUTY_W'(got.drive_a));
                    check_field("drive_b", DUTY_W'(want.drive_b), DUTY_W'(got.drive_b));
                    check_field("ramping", DUTY_W'(want.ramping), DUTY_W'(got.ramping));
                    check_field("running", DUTY_W'(want.running), DUTY_W'(got.running));
                end
            end
            // long hold-off so the block backs up into the request side
            if (output_hold_req) begin
                output_hold_req = 1'b0;
                hold_left       = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (steady_left != 0)
                    steady_left--;
                else if ($urandom_range(0, 99) < 2)
                    steady_left = $urandom_range(100, 300);
                else if ($urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    // ---------------- stimulus ----------------

    initial begin : stimulus
        step_row_t         directed[$];
        op_t               op;
        logic [DUTY_W-1:0] speed;
        logic [TICK_W-1:0] fade_pick;
        int unsigned       random_left;
        int unsigned       phase_len;
        int unsigned       ticks_owed;
        int unsigned       owed_cap;
        int unsigned       holds_asked;
        int unsigned       r;

        reset_predictor();

        // idle tick and idle stop, then a first ramp
        directed.push_back(row_known(OP_TICK, 8'd0, {8'd0, 1'b0, 1'b0, 1'b0, 1'b0}));
        directed.push_back(row_known(OP_STOP, 8'd0, {8'd0, 1'b0, 1'b0, 1'b0, 1'b0}));
        directed.push_back(row_known(OP_FORWARD, 8'd255, {8'd0, 1'b1, 1'b0, 1'b1, 1'b1}));
        directed.push_back(row_request(OP_TICK, 8'd0));
        // opposing command, then stop while the ramp down is running
        directed.push_back(row_request(OP_REVERSE, 8'd128));
        directed.push_back(row_request(OP_STOP, 8'd0));
        // zero duration: held reversal fires on the next tick
        directed.push_back(row_write(FADE_ADDR, 32'd0));
        directed.push_back(row_request(OP_TICK, 8'd0));
        directed.push_back(row_request(OP_TICK, 8'd0));
        directed.push_back(row_request(OP_STOP, 8'd0));
        directed.push_back(row_request(OP_TICK, 8'd0));
        directed.push_back(row_known(OP_STOP, 8'd0, {8'd0, 1'b0, 1'b1, 1'b0, 1'b0}));
        // longest ramp, upper data bits must be dropped, then shortened mid-ramp
        directed.push_back(row_write(FADE_ADDR, 32'ha5a5_ffff));
        directed.push_back(row_request(OP_REVERSE, 8'd255));
        directed.push_back(row_request(OP_TICK, 8'd0));
        directed.push_back(row_write(FADE_ADDR, 32'd1));
        directed.push_back(row_known(OP_TICK, 8'd0, {8'd255, 1'b0, 1'b1, 1'b0, 1'b1}));
        // unused register slot must not touch the ramp length
        directed.push_back(row_write(FADE_ADDR, 32'd5));
        directed.push_back(row_write(SPARE_ADDR, 32'd0));
        // falling ramps, re-issued opposing command, same-direction command keeps the hold
        directed.push_back(row_request(OP_FORWARD, 8'd0));
        directed.push_back(row_request(OP_TICK, 8'd0));
        directed.push_back(row_request(OP_FORWARD, 8'd200));
        directed.push_back(row_request(OP_REVERSE, 8'd50));
        repeat (5) directed.push_back(row_request(OP_TICK, 8'd0));
        // stop after the ramp ends clears the hold, speed ignored
        directed.push_back(row_request(OP_STOP, 8'd255));
        directed.push_back(row_request(OP_FORWARD, 8'd255));

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            if (directed[i].is_write)
                write_register(directed[i].addr, directed[i].data);
            else
                send_request(directed[i].op, directed[i].speed, directed[i].literal,
                             directed[i].want);
        end

        // random phases: one ramp length each, mostly commands followed by their ticks
        random_left = RANDOM_REQUESTS;
        holds_asked = 0;
        while (random_left != 0) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                fade_pick = '0;
            else if (r < 60)
                fade_pick = 16'($urandom_range(1, 6));
            else if (r < 88)
                fade_pick = 16'($urandom_range(7, 40));
            else if (r < 94)
                fade_pick = TICK_SAT;
            else
                fade_pick = 16'($urandom_range(41, 65534));
            if ($urandom_range(0, 9) == 0)
                write_register(SPARE_ADDR, $urandom);
            write_register(FADE_ADDR, {16'($urandom), fade_pick});

            phase_len     = (fade_pick > 40) ? $urandom_range(10, 30) : $urandom_range(40, 120);
            owed_cap      = (fade_pick > 18) ? 40 : 2 * fade_pick + 3;
            ticks_owed    = 0;
            sender_steady = ($urandom_range(0, 4) == 0);
            if (holds_asked < 2 && RANDOM_REQUESTS - random_left > 300 + 600 * holds_asked) begin
                output_hold_req = 1'b1;
                holds_asked++;
            end

            for (int unsigned n = 0; n < phase_len && random_left != 0; n++) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    op    = op_t'($urandom_range(0, 3));
                    speed = 8'($urandom);
                end else if (ticks_owed != 0 && r < 92) begin
                    op    = OP_TICK;
                    speed = 8'($urandom);
                    ticks_owed--;
                end else begin
                    r          = $urandom_range(0, 9);
                    op         = (r < 4) ? OP_FORWARD : (r < 8) ? OP_REVERSE : OP_STOP;
                    speed      = pick_speed();
                    ticks_owed = $urandom_range(0, owed_cap);
                end
                send_request(op, speed, 1'b0, '0);
                random_left--;
            end
        end

        // drain and let the block settle
        s_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("ran %0d requests (%0d ticks, %0d commands) over %0d register writes",
                 ticks_sent + commands_sent, ticks_sent, commands_sent, register_writes);
        $display("checked %0d results, %0d direction reversals completed, %0d errors",
                 results_checked, reversals_done, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
